@@ rtl/timestamp_ordered_event_queue_core_assert.svh @@
// Assertion macros for the timestamp-ordered event queue.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_CORE_ASSERT_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOEQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/toeq_pkg.sv @@
// Shared types and constants for the timestamp-ordered event queue.
// No dependencies; used by toeq_cell and timestamp_ordered_event_queue_core.
`default_nettype none

package toeq_pkg;

	// Field widths of the transfer payloads.
	localparam int TIME_BITS    = 32;
	localparam int DATA_BITS    = 32;
	localparam int HANDLER_BITS = 8;
	localparam int LEN_W        = 5;
	localparam int DEPTH_DEF    = 16;

	typedef enum logic {
		OP_SCHEDULE = 1'b0,
		OP_UPDATE   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACCEPTED   = 2'd0,
		KIND_DROPPED    = 2'd1,
		KIND_DISPATCHED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCHED,
		ST_UPDATE
	} state_t;

	// Request transfer payload.
	typedef struct packed {
		op_t                     operation;
		logic [TIME_BITS-1:0]    event_time;
		logic [HANDLER_BITS-1:0] handler_id;
		logic [DATA_BITS-1:0]    payload;
	} req_t;

	// Response transfer payload.
	typedef struct packed {
		kind_t                   kind;
		logic [TIME_BITS-1:0]    dispatch_time;
		logic [HANDLER_BITS-1:0] out_handler;
		logic [DATA_BITS-1:0]    out_payload;
		logic [LEN_W-1:0]        queue_length;
		logic                    last;
	} rsp_t;

	// One queue entry held in a cell.
	typedef struct packed {
		logic [TIME_BITS-1:0]    due;
		logic [HANDLER_BITS-1:0] handler;
		logic [DATA_BITS-1:0]    data;
	} entry_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/timestamp_ordered_event_queue_core.sv @@
// Channel | Dir | Payload | Transfer rule
// req     | in  | req_t   | req_valid && req_ready at a rising edge of clk
// rsp     | out | rsp_t   | rsp_valid && rsp_ready at a rising edge of clk
//
// A schedule request is captured, then inserted into the shift chain of cells, or dropped when full.
// An update request is captured, then dispatches its due entries one by one, since the chain
// pops its head once per cycle while rsp is free; with nothing due it ends without a response.
// The response register holds one result; a stalled rsp holds the chain until it drains.
// Reset (arst_n low) empties the queue and sets the current time to zero.
// Top level of the timestamp-ordered event queue; depends on toeq_pkg, toeq_cell and
// timestamp_ordered_event_queue_core_assert.svh.
`default_nettype none

`include "timestamp_ordered_event_queue_core_assert.svh"

module timestamp_ordered_event_queue_core
	import toeq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t               state_q, state_d;
	req_t                 req_q;
	rsp_t                 rsp_q, rsp_d;
	logic                 rsp_valid_q;
	logic                 rsp_load;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] cur_time_q, cur_time_d;
	logic                 cur_load;
	logic                 slot_free;
	logic                 full;
	logic                 head_ordered;
	logic [TIME_BITS-1:0] max_time;
	cell_cmd_t            cmd;
	entry_t               new_entry;
	entry_t               entry_w [QUEUE_DEPTH];
	logic                 keep_w  [QUEUE_DEPTH];

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign new_entry = '{due: req_q.event_time, handler: req_q.handler_id, data: req_q.payload};
	assign max_time  = (entry_w[0].due > cur_time_q) ? entry_w[0].due : cur_time_q;

	// The two front cells are in due-time order whenever both are occupied.
	assign head_ordered = (entry_w[0].due <= entry_w[1].due);

	// Chain of cells, head at index zero.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;

		if (i == 0) begin : g_head
			assign left_e = new_entry;
			assign left_k = 1'b1;
		end else begin : g_body
			assign left_e = entry_w[i-1];
			assign left_k = keep_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = entry_w[i];
		end else begin : g_inner
			assign right_e = entry_w[i+1];
		end

		toeq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (count_q > CNT_W'(i)),
			.new_time    (req_q.event_time),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.left_keep   (left_k),
			.right_entry (right_e),
			.entry       (entry_w[i]),
			.keep        (keep_w[i])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req.operation == OP_UPDATE) ? ST_UPDATE : ST_SCHED;
				end
			end
			ST_SCHED: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_UPDATE: begin
				if (!keep_w[0] || (slot_free && !keep_w[1])) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Chain commands, response contents and current time update.
	always_comb begin
		cmd        = '0;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		cur_load   = 1'b0;
		cur_time_d = req_q.event_time;
		unique case (state_q)
			ST_SCHED: begin
				if (slot_free) begin
					rsp_load   = 1'b1;
					rsp_d.last = 1'b1;
					if (full) begin
						rsp_d.kind         = KIND_DROPPED;
						rsp_d.queue_length = LEN_W'(count_q);
					end else begin
						cmd.insert         = 1'b1;
						rsp_d.kind         = KIND_ACCEPTED;
						rsp_d.queue_length = LEN_W'(count_q + 1'b1);
					end
				end
			end
			ST_UPDATE: begin
				if (!keep_w[0]) begin
					cur_load = 1'b1;
				end else if (slot_free) begin
					cmd.pop             = 1'b1;
					rsp_load            = 1'b1;
					cur_load            = 1'b1;
					rsp_d.kind          = KIND_DISPATCHED;
					rsp_d.dispatch_time = max_time;
					rsp_d.out_handler   = entry_w[0].handler;
					rsp_d.out_payload   = entry_w[0].data;
					rsp_d.queue_length  = LEN_W'(count_q - 1'b1);
					rsp_d.last          = !keep_w[1];
					if (keep_w[1]) begin
						cur_time_d = max_time;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			cur_time_q  <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (cur_load) begin
				cur_time_q <= cur_time_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	`TOEQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
	`TOEQ_ASSERT_SAME(a_head_sorted, count_q > CNT_W'(1), head_ordered, "head out of order")
	`TOEQ_ASSERT_SAME(a_load_free, rsp_load, slot_free, "response overwritten before transfer")
	`TOEQ_ASSERT_NEXT(a_pop_nonempty, cmd.pop, $past(count_q) != '0, "pop from empty queue")

endmodule

`default_nettype wire

@@ rtl/toeq_cell.sv @@
// One cell of the sorted shift chain: holds a single entry and its comparator.
// Depends on toeq_pkg.
`default_nettype none

module toeq_cell
	import toeq_pkg::*;
(
	input  wire logic                 clk,
	input  wire cell_cmd_t            cmd,
	input  wire logic                 occupied,
	input  wire logic [TIME_BITS-1:0] new_time,
	input  wire entry_t               new_entry,
	input  wire entry_t               left_entry,
	input  wire logic                 left_keep,
	input  wire entry_t               right_entry,
	output entry_t                    entry,
	output logic                      keep
);

	entry_t entry_q;

	// A held entry stays in place on insert when its due time is not later than the new one.
	assign keep  = occupied && (entry_q.due <= new_time);
	assign entry = entry_q;

	// Insert: the first cell that does not keep takes the new entry, later cells shift right.
	// Pop: every cell takes its right neighbor, the tail cell its own entry.
	always_ff @(posedge clk) begin
		priority if (cmd.insert && !keep) begin
			entry_q <= left_keep ? new_entry : left_entry;
		end else if (cmd.pop) begin
			entry_q <= right_entry;
		end else begin
			entry_q <= entry_q;
		end
	end

endmodule

`default_nettype wire

@@ sim/tb_timestamp_ordered_event_queue_core.sv @@
// Self-checking testbench for timestamp_ordered_event_queue_core: a directed table of
// requests, then random traffic, with every response checked against table values or a sorted-queue predictor.
// Depends on toeq_pkg and the core RTL only.
`default_nettype none

module tb_timestamp_ordered_event_queue_core;
	import toeq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 40;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_ITEMS = 52;

	// How a row of the directed table is checked.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_ONE,
		ROW_NONE
	} row_check_t;

	typedef struct {
		req_t       stim;
		row_check_t check;
		rsp_t       want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Predictor state: the sorted queue and the current time.
	logic [TIME_BITS-1:0]    sorted_due[QDEPTH];
	logic [HANDLER_BITS-1:0] sorted_handler[QDEPTH];
	logic [DATA_BITS-1:0]    sorted_data[QDEPTH];
	int                      held_count = 0;
	logic [TIME_BITS-1:0]    sim_now = '0;

	rsp_t       outstanding_events[$];
	table_row_t directed_rows[$];

	int send_idle = 21;
	int recv_idle = 47;
	int cycle_count = 0;
	int mismatch_count = 0;

	timestamp_ordered_event_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The receiver stalls at random at the current idle rate.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// Apply one accepted request to the sorted queue, and queue up the responses it causes
	// when keep is set.
	function automatic void advance_event_queue(req_t r, bit keep);
		rsp_t o;
		int   pos;
		if (r.operation == OP_SCHEDULE) begin
			o = '0;
			o.last = 1'b1;
			if (held_count >= QDEPTH) begin
				o.kind = KIND_DROPPED;
			end else begin
				// Insert after every entry due at or before the new one, so ties stay in order.
				pos = 0;
				while (pos < held_count && sorted_due[pos] <= r.event_time)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					sorted_due[i]     = sorted_due[i-1];
					sorted_handler[i] = sorted_handler[i-1];
					sorted_data[i]    = sorted_data[i-1];
				end
				sorted_due[pos]     = r.event_time;
				sorted_handler[pos] = r.handler_id;
				sorted_data[pos]    = r.payload;
				held_count++;
				o.kind = KIND_ACCEPTED;
			end
			o.queue_length = LEN_W'(held_count);
			if (keep)
				outstanding_events.push_back(o);
		end else begin
			// Pop every due entry; the dispatch time is a running maximum.
			while (held_count > 0 && sorted_due[0] <= r.event_time) begin
				if (sorted_due[0] > sim_now)
					sim_now = sorted_due[0];
				o.kind          = KIND_DISPATCHED;
				o.dispatch_time = sim_now;
				o.out_handler   = sorted_handler[0];
				o.out_payload   = sorted_data[0];
				for (int i = 1; i < held_count; i++) begin
					sorted_due[i-1]     = sorted_due[i];
					sorted_handler[i-1] = sorted_handler[i];
					sorted_data[i-1]    = sorted_data[i];
				end
				held_count--;
				o.queue_length = LEN_W'(held_count);
				o.last = !(held_count > 0 && sorted_due[0] <= r.event_time);
				if (keep)
					outstanding_events.push_back(o);
			end
			sim_now = r.event_time;
		end
	endfunction

	// Compare each response transfer with the oldest outstanding one.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (outstanding_events.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected response: kind %0d time %h handler %h data %h len %0d last %0d",
						rsp.kind, rsp.dispatch_time, rsp.out_handler, rsp.out_payload,
						rsp.queue_length, rsp.last);
			end else begin
				want = outstanding_events.pop_front();
				if (rsp.kind !== want.kind || rsp.dispatch_time !== want.dispatch_time
						|| rsp.out_handler !== want.out_handler
						|| rsp.out_payload !== want.out_payload
						|| rsp.queue_length !== want.queue_length || rsp.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("mismatch expected: kind %0d time %h handler %h data %h len %0d last %0d",
							want.kind, want.dispatch_time, want.out_handler, want.out_payload,
							want.queue_length, want.last);
						$display("           actual: kind %0d time %h handler %h data %h len %0d last %0d",
							rsp.kind, rsp.dispatch_time, rsp.out_handler, rsp.out_payload,
							rsp.queue_length, rsp.last);
					end
				end
			end
		end
	end

	// Drive one request, holding it until the transfer happens, after a random gap.
	task automatic send_request(req_t r, bit keep);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		advance_event_queue(r, keep);
	endtask

	function automatic void add_row(op_t op, logic [TIME_BITS-1:0] t,
			logic [HANDLER_BITS-1:0] h, logic [DATA_BITS-1:0] d, row_check_t check,
			kind_t kind, int len);
		table_row_t row;
		row.stim.operation  = op;
		row.stim.event_time = t;
		row.stim.handler_id = h;
		row.stim.payload    = d;
		row.check = check;
		row.want = '0;
		row.want.kind = kind;
		row.want.queue_length = LEN_W'(len);
		row.want.last = 1'b1;
		directed_rows.push_back(row);
	endfunction

	// Random request: times cluster around the current time, with ties, jumps, backward
	// limits and full flushes mixed in.
	function automatic req_t random_request(int sched_pct);
		req_t r;
		int   sel;
		sel = $urandom_range(0, 9);
		r.handler_id = HANDLER_BITS'($urandom_range(0, 255));
		r.payload = $urandom();
		if ($urandom_range(0, 99) < sched_pct) begin
			r.operation = OP_SCHEDULE;
			if (sel == 0)
				r.event_time = $urandom();
			else if (sel < 3)
				r.event_time = sim_now + 10 * $urandom_range(0, 3);
			else
				r.event_time = sim_now + $urandom_range(0, 200);
		end else begin
			r.operation = OP_UPDATE;
			if (sel == 0)
				r.event_time = $urandom();
			else if (sel == 1)
				r.event_time = sim_now - $urandom_range(0, 50);
			else if (sel == 9)
				r.event_time = '1;
			else
				r.event_time = sim_now + $urandom_range(0, 150);
		end
		return r;
	endfunction

	initial begin
		int sched_pct;

		// Directed table: extremes, ties, a full queue, backward limits and empty updates.
		add_row(OP_SCHEDULE, '0, '0, '0, ROW_ONE, KIND_ACCEPTED, 1);
		add_row(OP_SCHEDULE, '1, '1, '1, ROW_ONE, KIND_ACCEPTED, 2);
		add_row(OP_SCHEDULE, 100, 8'h01, 32'hA5A5_A5A5, ROW_ONE, KIND_ACCEPTED, 3);
		add_row(OP_SCHEDULE, 100, 8'h02, 32'h5A5A_5A5A, ROW_ONE, KIND_ACCEPTED, 4);
		add_row(OP_SCHEDULE, 50, 8'h03, 32'h0000_0001, ROW_ONE, KIND_ACCEPTED, 5);
		add_row(OP_UPDATE, 100, '0, '0, ROW_PREDICT, KIND_DISPATCHED, 0);
		// Fill to the brim with entries already overdue.
		for (int i = 0; i < QDEPTH - 1; i++)
			add_row(OP_SCHEDULE, 10 + (i % 4), 8'(16 + i), 32'h0100_0000 + i, ROW_ONE,
				KIND_ACCEPTED, 2 + i);
		add_row(OP_SCHEDULE, 7, 8'h77, 32'h7777_7777, ROW_ONE, KIND_DROPPED, QDEPTH);
		add_row(OP_UPDATE, 15, '0, '0, ROW_PREDICT, KIND_DISPATCHED, 0);
		add_row(OP_UPDATE, '1, '0, '0, ROW_PREDICT, KIND_DISPATCHED, 0);
		add_row(OP_UPDATE, '0, '0, '0, ROW_NONE, KIND_DISPATCHED, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].check == ROW_ONE)
				outstanding_events.push_back(directed_rows[n].want);
			send_request(directed_rows[n].stim, directed_rows[n].check == ROW_PREDICT);
		end

		// Random traffic in three idling phases.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 21 : (phase == 1) ? 47 : 0;
			recv_idle = (phase == 0) ? 47 : (phase == 1) ? 21 : 0;
			sched_pct = 60;
			for (int k = 0; k < RANDOM_ITEMS; k++) begin
				if (k % 20 == 0)
					sched_pct = $urandom_range(35, 85);
				send_request(random_request(sched_pct), 1'b1);
			end
		end
		req_valid <= 1'b0;

		while (outstanding_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && outstanding_events.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
